// ===== sv/sbf_pkg.sv =====
// Shared types and constants of the spring and bungee force pipeline.
`default_nettype none
package sbf_pkg;

    // Operation codes.
    localparam logic OP_SPRING = 1'b0;
    localparam logic OP_BUNGEE = 1'b1;

    // Bits of the floored square root of the summed squares.
    localparam int ROOT_W    = 34;
    // Quotient bits produced by the divider, one per stage.
    localparam int DIV_STEPS = 32;

    // Geometry and spring data carried alongside the length computation.
    typedef struct packed {
        logic             op;
        logic [30:0]      k;
        logic [30:0]      rest;
        logic [2:0][32:0] mag;
        logic [2:0]       neg;
    } geo_t;

    // Numerators and divisor handed to the divider.
    typedef struct packed {
        logic [2:0][97:0] num;
        logic [49:0]      den;
        logic [2:0]       fneg;
        logic             applied;
        logic             zero;
    } quo_in_t;

    // One stage of the restoring divider, also its final result.
    typedef struct packed {
        logic [2:0][49:0] rem;
        logic [2:0][31:0] q;
        logic [2:0][31:0] nlo;
        logic [49:0]      den;
        logic [2:0]       presat;
        logic [2:0]       fneg;
        logic             applied;
        logic             zero;
    } div_st_t;

endpackage
`default_nettype wire

// ===== sv/sbf_front.sv =====
// Front stages: position differences, their squares and the sum of squares.
`default_nettype none
module sbf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic              op,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic signed [31:0] qx,
    input  logic signed [31:0] qy,
    input  logic signed [31:0] qz,
    input  logic [30:0]       k,
    input  logic [30:0]       rest,
    output logic              out_valid,
    output logic [67:0]       sum,
    output sbf_pkg::geo_t     geo
);
    import sbf_pkg::*;

    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;
    geo_t             geo1_next;
    geo_t             geo1_reg;
    geo_t             geo2_reg;
    geo_t             geo3_reg;
    logic [2:0][65:0] sq_reg;
    logic [67:0]      sum_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;

    assign pa = {pz, py, px};
    assign pb = {qz, qy, qx};

    always_comb
    begin
        logic [32:0] diff;
        geo1_next      = '0;
        geo1_next.op   = op;
        geo1_next.k    = k;
        geo1_next.rest = rest;
        for (int i = 0; i < 3; i++)
        begin
            diff              = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
            geo1_next.neg[i]  = diff[32];
            geo1_next.mag[i]  = diff[32] ? 33'(-diff) : diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo1_reg <= geo1_next;
            geo2_reg <= geo1_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 66'(geo1_reg.mag[i]) * 66'(geo1_reg.mag[i]);
            end
            geo3_reg <= geo2_reg;
            sum_reg  <= 68'(sq_reg[0]) + 68'(sq_reg[1]) + 68'(sq_reg[2]);
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;
    assign geo       = geo3_reg;

endmodule
`default_nettype wire

// ===== sv/sbf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module sbf_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [67:0]                sum,
    input  sbf_pkg::geo_t              geo_in,
    output logic                       out_valid,
    output logic [sbf_pkg::ROOT_W-1:0] root,
    output sbf_pkg::geo_t              geo_out
);
    import sbf_pkg::*;

    logic [67:0]       rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    geo_t              geo_reg  [ROOT_W];
    logic              v_reg    [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_step
        localparam int B = ROOT_W - 1 - g;
        logic [67:0]       rem_cur;
        logic [67:0]       trial;
        logic [ROOT_W-1:0] root_cur;
        geo_t              geo_cur;
        logic              v_cur;
        logic              take;

        if (g == 0)
        begin : g_first
            assign rem_cur  = sum;
            assign root_cur = '0;
            assign geo_cur  = geo_in;
            assign v_cur    = in_valid;
        end
        else
        begin : g_rest
            assign rem_cur  = rem_reg[g-1];
            assign root_cur = root_reg[g-1];
            assign geo_cur  = geo_reg[g-1];
            assign v_cur    = v_reg[g-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign trial = (68'(root_cur) << (B + 1)) | (68'(1) << (2 * B));
        assign take  = rem_cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? rem_cur - trial : rem_cur;
                root_reg[g] <= take ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
                geo_reg[g]  <= geo_cur;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign geo_out   = geo_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ===== sv/sbf_scale.sv =====
// Extension from rest length and the numerator products k*|e|*|d|.
`default_nettype none
module sbf_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [sbf_pkg::ROOT_W-1:0] root,
    input  sbf_pkg::geo_t              geo,
    output logic                       out_valid,
    output sbf_pkg::quo_in_t           qin
);
    import sbf_pkg::*;

    typedef struct packed {
        logic             eneg;
        logic             slack;
        logic             zero;
        logic [2:0][32:0] mag;
        logic [2:0]       neg;
        logic [33:0]      root;
    } car_t;

    logic [35:0]      e_w;
    car_t             car_next;
    logic [33:0]      abse_next;
    car_t             car_a_reg;
    car_t             car_b_reg;
    car_t             car_c_reg;
    car_t             car_d_reg;
    logic [33:0]      abse_a_reg;
    logic [30:0]      k_a_reg;
    logic [47:0]      p0_reg;
    logic [47:0]      p1_reg;
    logic [64:0]      ke_reg;
    logic [2:0][65:0] pl_reg;
    logic [2:0][64:0] ph_reg;
    quo_in_t          qin_next;
    quo_in_t          qin_reg;
    logic [4:0]       v_reg;

    always_comb
    begin
        e_w            = 36'(root) - 36'(geo.rest);
        abse_next      = e_w[35] ? 34'(-e_w) : e_w[33:0];
        car_next.eneg  = e_w[35];
        car_next.slack = (geo.op == OP_BUNGEE) && (e_w[35] || (e_w == '0));
        car_next.zero  = (root == '0);
        car_next.mag   = geo.mag;
        car_next.neg   = geo.neg;
        car_next.root  = root;
    end

    always_comb
    begin
        qin_next.den     = {car_d_reg.root, 16'b0};
        qin_next.applied = !car_d_reg.slack;
        qin_next.zero    = car_d_reg.zero;
        for (int i = 0; i < 3; i++)
        begin
            qin_next.num[i]  = 98'(pl_reg[i]) + (98'(ph_reg[i]) << 33);
            qin_next.fneg[i] = (car_d_reg.eneg == car_d_reg.neg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car_a_reg  <= car_next;
            abse_a_reg <= abse_next;
            k_a_reg    <= geo.k;

            car_b_reg  <= car_a_reg;
            p0_reg     <= 48'(k_a_reg) * 48'(abse_a_reg[16:0]);
            p1_reg     <= 48'(k_a_reg) * 48'(abse_a_reg[33:17]);

            car_c_reg  <= car_b_reg;
            ke_reg     <= 65'(p0_reg) + (65'(p1_reg) << 17);

            car_d_reg  <= car_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= 66'(ke_reg[32:0]) * 66'(car_c_reg.mag[i]);
                ph_reg[i] <= 65'(ke_reg[64:33]) * 65'(car_c_reg.mag[i]);
            end

            qin_reg <= qin_next;
        end
    end

    assign out_valid = v_reg[4];
    assign qin       = qin_reg;

endmodule
`default_nettype wire

// ===== sv/sbf_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sbf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  sbf_pkg::quo_in_t  qin,
    output logic              out_valid,
    output sbf_pkg::div_st_t  res
);
    import sbf_pkg::*;

    div_st_t st_reg [DIV_STEPS+1];
    logic    v_reg  [DIV_STEPS+1];
    div_st_t entry_next;

    // A quotient of 2^32 or more is certain to clip, so only 32 bits are formed.
    always_comb
    begin
        entry_next.den     = qin.den;
        entry_next.fneg    = qin.fneg;
        entry_next.applied = qin.applied;
        entry_next.zero    = qin.zero;
        entry_next.q       = '0;
        for (int i = 0; i < 3; i++)
        begin
            entry_next.presat[i] = qin.num[i] >= {16'b0, qin.den, 32'b0};
            entry_next.rem[i]    = qin.num[i][81:32];
            entry_next.nlo[i]    = qin.num[i][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= entry_next;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_step
        div_st_t step_next;

        always_comb
        begin
            logic [50:0] t;
            logic        ge;
            step_next = st_reg[g];
            for (int i = 0; i < 3; i++)
            begin
                t  = {st_reg[g].rem[i], st_reg[g].nlo[i][31]};
                ge = t >= {1'b0, st_reg[g].den};
                step_next.rem[i] = ge ? 50'(t - {1'b0, st_reg[g].den}) : t[49:0];
                step_next.q[i]   = {st_reg[g].q[i][30:0], ge};
                step_next.nlo[i] = {st_reg[g].nlo[i][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g+1] <= step_next;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign res       = st_reg[DIV_STEPS];

endmodule
`default_nettype wire

// ===== sv/spring_bungee_force_unit.sv =====
// Top level of the spring and bungee force pipeline.
// The unit takes one request per cycle, while in_stall is low, on the input
// channel (in_valid and in_stall) carrying a particle position, a partner
// position, a stiffness, a rest length and an operation, and returns one force
// result per request on the output channel (out_valid and out_stall), in request order.
// The pipeline has three front stages for differences and squares, 34
// square-root stages (one root bit each), five scaling and multiply stages,
// 33 divider stages (an entry stage that spots a quotient of 2^32 or more,
// then 32 stages of one quotient bit each) and the output register.
// Throughput is one request per cycle while the receiver takes results.
// All stages advance together; when a result waits in the output register and
// the receiver stalls, the whole pipeline holds and in_stall rises, so nothing
// is lost or repeated and the stalled result stays unchanged.
// Reset clears every valid bit, so the pipeline starts empty and the first
// request is taken in the cycle after reset is released.
`default_nettype none
module spring_bungee_force_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic signed [31:0] particle_x,
    input  logic signed [31:0] particle_y,
    input  logic signed [31:0] particle_z,
    input  logic signed [31:0] partner_x,
    input  logic signed [31:0] partner_y,
    input  logic signed [31:0] partner_z,
    input  logic [30:0]       stiffness,
    input  logic [30:0]       natural_length,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic              force_applied,
    output logic              saturated
);
    import sbf_pkg::*;

    logic              en;
    logic              fr_valid;
    logic [67:0]       fr_sum;
    geo_t              fr_geo;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    geo_t              sq_geo;
    logic              sc_valid;
    quo_in_t           sc_qin;
    logic              dv_valid;
    div_st_t           dv_res;

    logic [2:0][31:0]  force_next;
    logic              sat_next;
    logic [2:0][31:0]  force_reg;
    logic              applied_reg;
    logic              sat_reg;
    logic              out_valid_reg;

    // The pipeline moves only when the output register is free or being taken.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    sbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .op        (operation),
        .px        (particle_x),
        .py        (particle_y),
        .pz        (particle_z),
        .qx        (partner_x),
        .qy        (partner_y),
        .qz        (partner_z),
        .k         (stiffness),
        .rest      (natural_length),
        .out_valid (fr_valid),
        .sum       (fr_sum),
        .geo       (fr_geo)
    );

    sbf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .sum       (fr_sum),
        .geo_in    (fr_geo),
        .out_valid (sq_valid),
        .root      (sq_root),
        .geo_out   (sq_geo)
    );

    sbf_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .geo       (sq_geo),
        .out_valid (sc_valid),
        .qin       (sc_qin)
    );

    sbf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .qin       (sc_qin),
        .out_valid (dv_valid),
        .res       (dv_res)
    );

    // Final rounding (half away from zero on the magnitude), sign and clipping.
    // A slack bungee and a zero-length spring both give a zero force.
    always_comb
    begin
        logic [32:0] q1;
        logic        up;
        force_next = '0;
        sat_next   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            up = {dv_res.rem[i], 1'b0} >= {1'b0, dv_res.den};
            q1 = 33'(dv_res.q[i]) + 33'(up);
            if (!dv_res.applied || dv_res.zero)
            begin
                force_next[i] = '0;
            end
            else if (dv_res.presat[i])
            begin
                sat_next      = 1'b1;
                force_next[i] = dv_res.fneg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (q1 == '0)
            begin
                force_next[i] = '0;
            end
            else if (dv_res.fneg[i])
            begin
                if (q1 > 33'h0_8000_0000)
                begin
                    sat_next      = 1'b1;
                    force_next[i] = 32'h8000_0000;
                end
                else
                begin
                    force_next[i] = 32'(-q1);
                end
            end
            else
            begin
                if (q1 > 33'h0_7FFF_FFFF)
                begin
                    sat_next      = 1'b1;
                    force_next[i] = 32'h7FFF_FFFF;
                end
                else
                begin
                    force_next[i] = q1[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            force_reg   <= force_next;
            applied_reg <= dv_res.applied;
            sat_reg     <= sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign force_x       = force_reg[0];
    assign force_y       = force_reg[1];
    assign force_z       = force_reg[2];
    assign force_applied = applied_reg;
    assign saturated     = sat_reg;

endmodule
`default_nettype wire
